// ===== rtl/plc_pkg.sv =====
// Shared types and codes for the positional list core.
`timescale 1ns / 1ps

package plc_pkg;

  // Request operation codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_POS   = 2'd1;
  localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

  // One incoming request.
  typedef struct packed {
    logic               mode;
    logic [4:0]         position;
    logic signed [63:0] value;
  } plc_req_t;

  // One result.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] removed_value;
    logic [4:0]         element_count;
  } plc_rsp_t;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic shift_back;   // insert: cells at or after the position move back
    logic shift_fwd;    // delete: cells at or after the position move forward
  } plc_ctrl_t;

endpackage

// ===== rtl/plc_cell.sv =====
// One storage cell of the list row, holding the element at a fixed index.
`timescale 1ns / 1ps

module plc_cell
  import plc_pkg::*;
#(
  parameter int DW  = 64,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  plc_ctrl_t       ctrl,
  input  logic [CW-1:0]   pos,
  input  logic [DW-1:0]   ins_data,
  input  logic [DW-1:0]   prev_data,
  input  logic [DW-1:0]   next_data,
  output logic [DW-1:0]   data,
  output logic [DW-1:0]   hit_data
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;
  logic          at_pos;
  logic          after_pos;

  assign at_pos    = (MY_IDX == pos);
  assign after_pos = (MY_IDX > pos);

  // Pick the new content from the neighbors or the inserted value.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_back) begin
      if (after_pos) begin
        data_nxt = prev_data;
      end else if (at_pos) begin
        data_nxt = ins_data;
      end
    end else if (ctrl.shift_fwd) begin
      if (after_pos || at_pos) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // Only the addressed cell drives the removal bus.
  assign hit_data = at_pos ? data_r : '0;

endmodule

// ===== rtl/positional_list_insert_delete_core.sv =====
// Top level of the positional list: request checks, cell row and result buffer.
`timescale 1ns / 1ps

// The core holds an ordered list of up to CAPACITY signed elements and takes
// one insert-at-position or delete-at-position request per cycle while in_stall
// is low. Every cell of the row compares its own index with the requested
// position, so a whole shift of the list completes in the cycle that accepts
// the request; the result is registered, in the skid entry if the output is
// stalled. A two-entry result buffer lets the core accept one more request
// while a result is stalled; in_stall rises only once both entries hold
// results. Status, removed value and element count are given for every request;
// a rejected request leaves the list as it was. Stored elements keep the low
// DATA_WIDTH bits of value; removed values are sign extended back to 64 bits.

module positional_list_insert_delete_core
  import plc_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  plc_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output plc_rsp_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  plc_ctrl_t       ctrl;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_hit  [CAPACITY];
  logic [DATA_WIDTH-1:0] hit_any;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   cnt_w;
  logic            accept;
  logic            full;
  plc_rsp_t        rsp;

  plc_rsp_t        out_r;
  plc_rsp_t        out_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  plc_rsp_t        skid_r;
  plc_rsp_t        skid_nxt;
  logic            skid_valid_r;
  logic            skid_valid_nxt;

  assign accept   = in_valid && !skid_valid_r;
  assign pos_w    = PW'(in_data.position);
  assign cnt_w    = PW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign ins_data = in_data.value[DATA_WIDTH-1:0];

  // Check the request and decide the shift and the result.
  always_comb begin
    ctrl          = '0;
    count_nxt     = count_r;
    rsp.status    = STATUS_OK;
    rsp.removed_value = '0;
    if (in_data.mode == MODE_INSERT) begin
      if (pos_w > cnt_w) begin
        rsp.status = STATUS_BAD_POS;
      end else if (full) begin
        rsp.status = STATUS_LIST_FULL;
      end else begin
        ctrl.shift_back = accept;
        count_nxt       = count_r + CW'(1);
      end
    end else begin
      if (pos_w >= cnt_w) begin
        rsp.status = STATUS_BAD_POS;
      end else begin
        ctrl.shift_fwd    = accept;
        count_nxt         = count_r - CW'(1);
        rsp.removed_value = 64'($signed(hit_any));
      end
    end
    rsp.element_count = 5'(count_nxt);
  end

  // The row of cells; the ends see zero from outside the list.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;
    if (g == 0) begin : g_head
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[g+1];
    end
    plc_cell #(
      .DW  (DATA_WIDTH),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (CW'(in_data.position)),
      .ins_data  (ins_data),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[g]),
      .hit_data  (cell_hit[g])
    );
  end

  // Gather the addressed element; at most one cell drives nonzero.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any = hit_any | cell_hit[i];
    end
  end

  // Result buffer: a main output register backed by one skid entry.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = rsp;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = rsp;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== bench/tb_positional_list_insert_delete_core.sv =====
// Self-checking bench for the positional list core: directed table, then random requests.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_core;
  import plc_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int DATA_WIDTH      = 64;
  localparam int RANDOM_REQUESTS = 700;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct {
    plc_req_t req;
    bit       typed;
    plc_rsp_t rsp;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  plc_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  plc_rsp_t out_data;

  // Typed expectation that travels alongside the request being offered.
  logic     req_typed;
  plc_rsp_t req_typed_rsp;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;

  // Shadow copy of the list used to predict every result.
  logic signed [DATA_WIDTH-1:0] list_mem [CAPACITY];
  int       list_len = 0;
  plc_rsp_t pending_results [$];

  dir_row_t dir_rows [$];
  int       shadow_len = 0;
  int       error_count = 0;
  int       results_seen = 0;
  int       requests_taken = 0;
  int       idle_cycles = 0;
  int       peak_len = 0;
  int       status_hits [3];

  positional_list_insert_delete_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the result it must give.
  function automatic plc_rsp_t list_apply(input plc_req_t req);
    plc_rsp_t rsp;
    int       k;
    rsp        = '0;
    rsp.status = STATUS_OK;
    if (req.mode == MODE_INSERT) begin
      if (req.position > list_len) begin
        rsp.status = STATUS_BAD_POS;
      end else if (list_len >= CAPACITY) begin
        rsp.status = STATUS_LIST_FULL;
      end else begin
        for (k = list_len; k > req.position; k--) list_mem[k] = list_mem[k-1];
        list_mem[req.position] = req.value[DATA_WIDTH-1:0];
        list_len++;
      end
    end else begin
      if (req.position >= list_len) begin
        rsp.status = STATUS_BAD_POS;
      end else begin
        // Signed element, so the assignment sign extends it to 64 bits.
        rsp.removed_value = list_mem[req.position];
        for (k = req.position; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
        list_len--;
      end
    end
    rsp.element_count = 5'(list_len);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: result %0d %s mismatch: got %h, expected %h",
             $time, results_seen, what, got, want);
    error_count++;
  endtask

  function automatic void add_row(input logic mode, input int pos,
                                  input logic signed [63:0] value, input bit typed,
                                  input logic [1:0] status,
                                  input logic signed [63:0] removed, input int count);
    dir_row_t row;
    row.req.mode              = mode;
    row.req.position          = 5'(pos);
    row.req.value             = value;
    row.typed                 = typed;
    row.rsp.status            = status;
    row.rsp.removed_value     = removed;
    row.rsp.element_count     = 5'(count);
    dir_rows.push_back(row);
  endfunction

  // Random request: mostly positions that hit the list, some anywhere in the field.
  function automatic plc_req_t random_request(input int n);
    plc_req_t req;
    int       insert_pct;
    // Stretches of 50 requests lean toward filling, draining or churning.
    case ((n / 50) % 3)
      0:       insert_pct = 80;
      1:       insert_pct = 25;
      default: insert_pct = 50;
    endcase
    req.mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
    case ($urandom_range(7))
      0:       req.value = VAL_MAX;
      1:       req.value = VAL_MIN;
      2:       req.value = '0;
      3:       req.value = -64'sd1;
      default: req.value = {$urandom, $urandom};
    endcase
    if ($urandom_range(99) < 15) begin
      req.position = 5'($urandom_range(31));
    end else if (req.mode == MODE_INSERT) begin
      req.position = 5'($urandom_range(shadow_len));
    end else begin
      req.position = 5'($urandom_range(shadow_len == 0 ? 0 : shadow_len - 1));
    end
    return req;
  endfunction

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input plc_req_t req, input bit typed,
                              input plc_rsp_t typed_rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= req;
    req_typed     <= typed;
    req_typed_rsp <= typed_rsp;
    // Track the fill level so the next random positions can be steered.
    if (req.mode == MODE_INSERT) begin
      if (req.position <= shadow_len && shadow_len < CAPACITY) shadow_len++;
    end else if (req.position < shadow_len) begin
      shadow_len--;
    end
    do @(posedge clk); while (in_stall);
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0 && !hold_done) begin
        hold_left = hold_len;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Checks results in order, predicts each taken request, and guards against hangs.
  always @(posedge clk) begin : result_check
    plc_rsp_t want;
    plc_rsp_t predicted;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data.status), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.removed_value !== want.removed_value)
            report_mismatch("removed_value", out_data.removed_value, want.removed_value);
          if (out_data.element_count !== want.element_count)
            report_mismatch("element_count", 64'(out_data.element_count),
                            64'(want.element_count));
        end
      end
      if (in_valid && !in_stall) begin
        predicted = list_apply(in_data);
        pending_results.push_back(req_typed ? req_typed_rsp : predicted);
        if (predicted.status <= STATUS_LIST_FULL) status_hits[predicted.status]++;
        if (list_len > peak_len) peak_len = list_len;
        requests_taken++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_valid      <= 1'b0;
    in_data       <= '0;
    req_typed     <= 1'b0;
    req_typed_rsp <= '0;
    rst_n         <= 1'b0;

    // Empty list, extremes, head insert into a non-empty list and bad positions.
    add_row(MODE_DELETE, 0, 64'sh5A5A_A5A5_0F0F_F0F0, 1, STATUS_BAD_POS, 0, 0);
    add_row(MODE_INSERT, 31, 64'sd1, 1, STATUS_BAD_POS, 0, 0);
    add_row(MODE_INSERT, 0, VAL_MAX, 1, STATUS_OK, 0, 1);
    add_row(MODE_INSERT, 0, VAL_MIN, 1, STATUS_OK, 0, 2);
    add_row(MODE_INSERT, 2, 64'sd0, 1, STATUS_OK, 0, 3);
    add_row(MODE_INSERT, 1, -64'sd1, 1, STATUS_OK, 0, 4);
    add_row(MODE_DELETE, 4, VAL_MAX, 1, STATUS_BAD_POS, 0, 4);
    add_row(MODE_DELETE, 0, 64'sd0, 1, STATUS_OK, VAL_MIN, 3);
    add_row(MODE_DELETE, 1, -64'sd1, 0, STATUS_OK, 0, 0);
    add_row(MODE_DELETE, 16, 64'sd0, 1, STATUS_BAD_POS, 0, 2);
    // Fill the list to capacity at scattered positions.
    for (int i = 0; i < CAPACITY - 2; i++)
      add_row(MODE_INSERT, (i * 3) % (i + 3), {$urandom, $urandom}, 0, STATUS_OK, 0, 0);
    // Full list: a valid position reports full, a bad one reports the position.
    add_row(MODE_INSERT, 5, 64'sd7, 1, STATUS_LIST_FULL, 0, 16);
    add_row(MODE_INSERT, 17, 64'sd7, 1, STATUS_BAD_POS, 0, 16);
    add_row(MODE_DELETE, 15, 64'sd0, 0, STATUS_OK, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 6;
    recv_idle_pct = 81;
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 300) begin
        send_idle_pct = 81;
        recv_idle_pct = 6;
      end
      if (n == 600) begin
        // No idling from here on, and the output is held off so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len <= HOLD_OFF_CYCLES;
      end
      send_request(random_request(n), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain every outstanding result, then allow a few quiet cycles.
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Checked %0d requests and %0d results: %0d ok, %0d bad position, %0d list full.",
             requests_taken, results_seen, status_hits[STATUS_OK],
             status_hits[STATUS_BAD_POS], status_hits[STATUS_LIST_FULL]);
    $display("List peaked at %0d elements under three stall mixes and one long output hold-off.",
             peak_len);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
